/* hdl/dual_flex_baseline_classifier_defines.svh */
// ---------------------------------------------------------------------------
// dual_flex_baseline_classifier_defines.svh
// Assertion macros used by the checker file.
// ---------------------------------------------------------------------------
`ifndef DUAL_FLEX_BASELINE_CLASSIFIER_DEFINES_SVH
`define DUAL_FLEX_BASELINE_CLASSIFIER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define DFBC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DFBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dfbc_pkg.sv */
// ---------------------------------------------------------------------------
// dfbc_pkg
// Shared widths, codes and control types of the flex baseline classifier.
// ---------------------------------------------------------------------------
package dfbc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam logic [SAMPLE_BITS-1:0] SMAX = '1;

  localparam int CNT_W = 16;
  localparam int TOL_W = 10;
  localparam int RUN_W = 8;
  localparam int LVL_W = 10;
  localparam int SEV_W = 3;
  localparam int PH_W  = 2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 80;
  localparam int OUT_TUSER_W = 3;
  localparam int OUT_USED_W  = 7 * SAMPLE_BITS + SEV_W;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
  localparam int IN_PAD_W    = IN_TDATA_W - 2 * SAMPLE_BITS;

  localparam logic [PH_W-1:0] PH_PRE  = 2'd0;
  localparam logic [PH_W-1:0] PH_CAL  = 2'd1;
  localparam logic [PH_W-1:0] PH_DONE = 2'd2;
  localparam logic [PH_W-1:0] PH_RUN  = 2'd3;

  localparam logic [SEV_W-1:0] SEV_NONE   = 3'd0;
  localparam logic [SEV_W-1:0] SEV_SUBCLN = 3'd1;
  localparam logic [SEV_W-1:0] SEV_MILD   = 3'd2;
  localparam logic [SEV_W-1:0] SEV_MOD    = 3'd3;
  localparam logic [SEV_W-1:0] SEV_SEVERE = 3'd4;

  localparam logic [CFG_ADDR_W-1:0] REG_CAL_SAMPLES = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WARMUP      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RUN_NEEDED  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_LVL_SUBCLN  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_LVL_MILD    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LVL_MOD     = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_LVL_SEVERE  = 3'd7;

  // per-beat control from the sequencer to both channels
  typedef struct packed {
    logic            step;      // beat moves into the result register
    logic [PH_W-1:0] phase;     // PH_PRE, PH_CAL or PH_RUN
    logic            pre_done;  // pre-mean completes on this beat
    logic            track_en;  // past warm-up, stability tracking on
    logic            ending;    // calibration ends on this beat
  } dfbc_ctl_t;

endpackage

/* hdl/dfbc_channel.sv */
// ---------------------------------------------------------------------------
// dfbc_channel
// One sensor channel: pre-mean accumulator, moving-average ring, stability
// run, running minimum and baseline.
// ---------------------------------------------------------------------------
module dfbc_channel #(
  parameter int AVG_TAPS    = 10,
  parameter int PRE_SAMPLES = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dfbc_pkg::dfbc_ctl_t               ctl,
  input  logic [dfbc_pkg::SAMPLE_BITS-1:0]  raw,
  input  logic [dfbc_pkg::TOL_W-1:0]        tol,
  input  logic [dfbc_pkg::RUN_W-1:0]        run_needed,
  output logic [dfbc_pkg::SAMPLE_BITS-1:0]  smooth,
  output logic [dfbc_pkg::SAMPLE_BITS-1:0]  base,
  output logic [dfbc_pkg::SAMPLE_BITS-1:0]  dev
);
  import dfbc_pkg::*;

  localparam int POS_W  = (AVG_TAPS > 1) ? $clog2(AVG_TAPS) : 1;
  localparam int SUM_W  = SAMPLE_BITS + $clog2(AVG_TAPS + 1);
  localparam int TAP_SH = SUM_W + $clog2(AVG_TAPS);
  localparam int TAP_MW = SUM_W + 1;
  localparam int TAP_PW = SUM_W + TAP_MW;
  localparam logic [TAP_MW-1:0] TAP_M =
    TAP_MW'(((64'd1 << TAP_SH) + 64'(AVG_TAPS) - 64'd1) / 64'(AVG_TAPS));
  localparam int ACC_W  = SAMPLE_BITS + $clog2(PRE_SAMPLES + 1);
  localparam int PRE_SH = ACC_W + $clog2(PRE_SAMPLES);
  localparam int PRE_MW = ACC_W + 1;
  localparam int PRE_PW = ACC_W + PRE_MW;
  localparam logic [PRE_MW-1:0] PRE_M =
    PRE_MW'(((64'd1 << PRE_SH) + 64'(PRE_SAMPLES) - 64'd1) / 64'(PRE_SAMPLES));
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(AVG_TAPS - 1);
  localparam logic [RUN_W-1:0] RUN_MAX  = '1;

  function automatic logic [SAMPLE_BITS-1:0] absdiff(
    input logic [SAMPLE_BITS-1:0] a,
    input logic [SAMPLE_BITS-1:0] b
  );
    return (a >= b) ? a - b : b - a;
  endfunction

  logic [SAMPLE_BITS-1:0] ring_r [AVG_TAPS];
  logic [SUM_W-1:0]       sum_r;
  logic [POS_W-1:0]       pos_r;
  logic [ACC_W-1:0]       pre_acc_r;
  logic [SAMPLE_BITS-1:0] pre_mean_r;
  logic [RUN_W-1:0]       run_r;
  logic [SAMPLE_BITS-1:0] min_r;
  logic [SAMPLE_BITS-1:0] baseline_r;

  logic [SAMPLE_BITS-1:0] old_val;
  logic [SUM_W-1:0]       sum_upd;
  logic [TAP_PW-1:0]      tap_prod;
  logic [ACC_W-1:0]       acc_upd;
  logic [PRE_PW-1:0]      pre_prod;
  logic [SAMPLE_BITS-1:0] mean_calc;
  logic                   stable;
  logic [RUN_W-1:0]       run_upd;
  logic [RUN_W-1:0]       run_nxt;
  logic [SAMPLE_BITS-1:0] min_nxt;
  logic [SAMPLE_BITS-1:0] mean_src;
  logic [SAMPLE_BITS-1:0] base_new;
  logic [SAMPLE_BITS-1:0] fill_val;
  logic [SUM_W-1:0]       fill_sum;
  logic                   do_fill;
  logic                   in_pre;
  logic [POS_W-1:0]       pos_adv;

  assign in_pre   = (ctl.phase == PH_PRE);
  assign old_val  = ring_r[pos_r];
  assign sum_upd  = sum_r - SUM_W'(old_val) + SUM_W'(raw);
  assign tap_prod = TAP_PW'(sum_upd) * TAP_PW'(TAP_M);
  assign smooth   = SAMPLE_BITS'(tap_prod >> TAP_SH);
  assign pos_adv  = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;

  assign acc_upd   = pre_acc_r + ACC_W'(raw);
  assign pre_prod  = PRE_PW'(acc_upd) * PRE_PW'(PRE_M);
  assign mean_calc = SAMPLE_BITS'(pre_prod >> PRE_SH);

  assign stable  = (TOL_W'(absdiff(raw, smooth)) <= tol);
  assign run_upd = !stable ? '0 : ((run_r == RUN_MAX) ? run_r : run_r + 1'b1);
  assign run_nxt = ctl.track_en ? run_upd : run_r;
  assign min_nxt = (ctl.track_en && (run_upd >= run_needed) && (smooth < min_r))
                   ? smooth : min_r;

  assign mean_src = in_pre ? mean_calc : pre_mean_r;
  assign base_new = (min_nxt == SMAX) ? mean_src : min_nxt;
  assign fill_val = ctl.ending ? base_new : mean_calc;
  assign fill_sum = SUM_W'(fill_val) * SUM_W'(AVG_TAPS);
  assign do_fill  = ctl.ending || (in_pre && ctl.pre_done);

  assign base = ctl.ending ? base_new : baseline_r;
  assign dev  = absdiff(smooth, baseline_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      pos_r      <= '0;
      pre_acc_r  <= '0;
      pre_mean_r <= '0;
      run_r      <= '0;
      min_r      <= SMAX;
      baseline_r <= '0;
    end else if (ctl.step) begin
      if (in_pre) begin
        pre_acc_r <= acc_upd;
        if (ctl.pre_done) begin
          pre_mean_r <= mean_calc;
        end
      end
      if (ctl.phase == PH_CAL) begin
        run_r <= run_nxt;
        min_r <= min_nxt;
      end
      if (ctl.ending) begin
        baseline_r <= base_new;
      end
      if (do_fill) begin
        sum_r <= fill_sum;
        pos_r <= '0;
      end else if (!in_pre) begin
        sum_r <= sum_upd;
        pos_r <= pos_adv;
      end
    end
  end

  // ring contents are preloaded when the pre-mean completes, before any value read from them is used
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (do_fill) begin
        for (int i = 0; i < AVG_TAPS; i++) begin
          ring_r[i] <= fill_val;
        end
      end else if (!in_pre) begin
        ring_r[pos_r] <= raw;
      end
    end
  end

endmodule

/* hdl/dual_flex_baseline_classifier.sv */
// ---------------------------------------------------------------------------
// dual_flex_baseline_classifier
// Two-channel flex sensor baseline calibration and severity classifier.
// ---------------------------------------------------------------------------
// channel | dir | beat contents
// in_     | in  | raw_first, raw_second
// out_    | out | smoothed values, baselines, deviations, severity + phase
// cfg_    | in  | one register write per cycle with cfg_we high
//
// One beat per cycle sustained while out_tready is high; a beat is held in the input
// register and moves into the output register once the output register is free or taken.
// All per-sample work is done by logic between those two registers.
// Reset (rst_n low, synchronous) returns to pre-mean phase, defaults reload.
// out_tready low holds the output beat; input accepts while a slot is free.
// ---------------------------------------------------------------------------
module dual_flex_baseline_classifier #(
  parameter int AVG_TAPS    = 10,
  parameter int PRE_SAMPLES = 5
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [9:0] raw_first, [19:10] raw_second
  input  logic [dfbc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [9:0] smooth_first, [19:10] smooth_second, [29:20] base_first,
  // [39:30] base_second, [49:40] dev_first, [59:50] dev_second,
  // [69:60] dev_total, [72:70] severity
  output logic [dfbc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // [1:0] phase, [2] data_valid
  output logic [dfbc_pkg::OUT_TUSER_W-1:0]  out_tuser,
  input  logic                              cfg_we,
  input  logic [dfbc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [dfbc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import dfbc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  logic [CNT_W-1:0] cal_samples_r;
  logic [CNT_W-1:0] warmup_r;
  logic [TOL_W-1:0] tol_r;
  logic [RUN_W-1:0] run_needed_r;
  logic [LVL_W-1:0] lvl_subcln_r;
  logic [LVL_W-1:0] lvl_mild_r;
  logic [LVL_W-1:0] lvl_mod_r;
  logic [LVL_W-1:0] lvl_severe_r;

  logic                     in_v_r;
  logic [SAMPLE_BITS-1:0]   raw_first_r;
  logic [SAMPLE_BITS-1:0]   raw_second_r;
  logic                     out_v_r;
  logic [OUT_TDATA_W-1:0]   out_data_r;
  logic [OUT_TUSER_W-1:0]   out_user_r;

  logic [PH_W-1:0]  phase_r;
  logic [PH_W-1:0]  phase_nxt;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  logic             adv;
  logic [PH_W-1:0]  ph_eff;
  logic [CNT_W-1:0] cnt_inc;
  logic             pre_done;
  logic             ending;
  dfbc_ctl_t        ctl;

  logic [SAMPLE_BITS-1:0] sm_first, sm_second;
  logic [SAMPLE_BITS-1:0] bs_first, bs_second;
  logic [SAMPLE_BITS-1:0] dv_first, dv_second;
  logic [SAMPLE_BITS:0]   dev_sum;
  logic [SAMPLE_BITS-1:0] dev_total;
  logic [SEV_W-1:0]       severity;
  logic                   run_ph;
  logic                   show_base;
  logic [PH_W-1:0]        ph_out;
  logic [SAMPLE_BITS-1:0] o_sm_first, o_sm_second, o_bs_first, o_bs_second;
  logic [SAMPLE_BITS-1:0] o_dv_first, o_dv_second, o_dev_total;
  logic [SEV_W-1:0]       o_severity;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_samples_r <= CNT_W'(300);
      warmup_r      <= CNT_W'(25);
      tol_r         <= TOL_W'(2);
      run_needed_r  <= RUN_W'(6);
      lvl_subcln_r  <= LVL_W'(3);
      lvl_mild_r    <= LVL_W'(5);
      lvl_mod_r     <= LVL_W'(10);
      lvl_severe_r  <= LVL_W'(20);
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CAL_SAMPLES: cal_samples_r <= cfg_wdata[CNT_W-1:0];
        REG_WARMUP:      warmup_r      <= cfg_wdata[CNT_W-1:0];
        REG_TOLERANCE:   tol_r         <= cfg_wdata[TOL_W-1:0];
        REG_RUN_NEEDED:  run_needed_r  <= cfg_wdata[RUN_W-1:0];
        REG_LVL_SUBCLN:  lvl_subcln_r  <= cfg_wdata[LVL_W-1:0];
        REG_LVL_MILD:    lvl_mild_r    <= cfg_wdata[LVL_W-1:0];
        REG_LVL_MOD:     lvl_mod_r     <= cfg_wdata[LVL_W-1:0];
        REG_LVL_SEVERE:  lvl_severe_r  <= cfg_wdata[LVL_W-1:0];
      endcase
    end
  end

  // ---- handshake
  assign adv        = in_v_r && (!out_v_r || out_tready);
  assign in_tready  = !in_v_r || adv;
  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      raw_first_r  <= in_tdata[SAMPLE_BITS-1:0];
      raw_second_r <= in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    end
  end

  // ---- phase sequencer
  assign ph_eff   = (phase_r == PH_DONE || phase_r == PH_RUN) ? PH_RUN : phase_r;
  assign cnt_inc  = (count_r == CNT_MAX) ? count_r : count_r + 1'b1;
  assign pre_done = (ph_eff == PH_PRE) && (cnt_inc >= CNT_W'(PRE_SAMPLES));
  assign ending   = ((ph_eff == PH_PRE) && pre_done && (cnt_inc >= cal_samples_r)) ||
                    ((ph_eff == PH_CAL) && (cnt_inc >= cal_samples_r));

  always_comb begin
    phase_nxt = ph_eff;
    count_nxt = count_r;
    if (ph_eff == PH_PRE || ph_eff == PH_CAL) begin
      count_nxt = cnt_inc;
    end
    priority if (ending) begin
      phase_nxt = PH_DONE;
    end else if (pre_done) begin
      phase_nxt = PH_CAL;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PRE;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  assign ctl.step     = adv;
  assign ctl.phase    = ph_eff;
  assign ctl.pre_done = pre_done;
  assign ctl.track_en = (ph_eff == PH_CAL) && (count_r >= warmup_r);
  assign ctl.ending   = ending;

  // ---- channels
  dfbc_channel #(
    .AVG_TAPS    (AVG_TAPS),
    .PRE_SAMPLES (PRE_SAMPLES)
  ) u_first (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .raw        (raw_first_r),
    .tol        (tol_r),
    .run_needed (run_needed_r),
    .smooth     (sm_first),
    .base       (bs_first),
    .dev        (dv_first)
  );

  dfbc_channel #(
    .AVG_TAPS    (AVG_TAPS),
    .PRE_SAMPLES (PRE_SAMPLES)
  ) u_second (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ctl),
    .raw        (raw_second_r),
    .tol        (tol_r),
    .run_needed (run_needed_r),
    .smooth     (sm_second),
    .base       (bs_second),
    .dev        (dv_second)
  );

  // ---- classification
  assign dev_sum   = {1'b0, dv_first} + {1'b0, dv_second};
  assign dev_total = dev_sum[SAMPLE_BITS:1];

  always_comb begin
    priority if (dev_total >= lvl_severe_r) begin
      severity = SEV_SEVERE;
    end else if (dev_total >= lvl_mod_r) begin
      severity = SEV_MOD;
    end else if (dev_total >= lvl_mild_r) begin
      severity = SEV_MILD;
    end else if (dev_total >= lvl_subcln_r) begin
      severity = SEV_SUBCLN;
    end else begin
      severity = SEV_NONE;
    end
  end

  assign run_ph    = (ph_eff == PH_RUN);
  assign show_base = run_ph || ending;
  assign ph_out    = ending ? PH_DONE : ph_eff;

  assign o_sm_first   = run_ph ? sm_first : '0;
  assign o_sm_second  = run_ph ? sm_second : '0;
  assign o_bs_first   = show_base ? bs_first : '0;
  assign o_bs_second  = show_base ? bs_second : '0;
  assign o_dv_first   = run_ph ? dv_first : '0;
  assign o_dv_second  = run_ph ? dv_second : '0;
  assign o_dev_total  = run_ph ? dev_total : '0;
  assign o_severity   = run_ph ? severity : SEV_NONE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, o_severity, o_dev_total, o_dv_second, o_dv_first,
                     o_bs_second, o_bs_first, o_sm_second, o_sm_first};
      out_user_r <= {run_ph, ph_out};
    end
  end

endmodule

/* hdl/dfbc_checker.sv */
// ---------------------------------------------------------------------------
// dfbc_checker
// Port-level checks of the classifier result stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "dual_flex_baseline_classifier_defines.svh"

module dfbc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [dfbc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input logic [dfbc_pkg::OUT_TUSER_W-1:0]  out_tuser
);
  import dfbc_pkg::*;

  logic                                stalled;
  logic                                res_dvalid;
  logic [PH_W-1:0]                     res_phase;
  logic [SEV_W-1:0]                    res_sev;
  logic                                is_run;
  logic                                is_early;
  logic                                base_zero;
  logic                                idle_zero;
  logic [OUT_TUSER_W+OUT_TDATA_W-1:0]  beat;

  assign stalled    = out_tvalid && !out_tready;
  assign res_dvalid = out_tuser[2];
  assign res_phase  = out_tuser[1:0];
  assign res_sev    = out_tdata[72:70];
  assign is_run     = (res_phase == PH_RUN);
  assign is_early   = (res_phase == PH_PRE) || (res_phase == PH_CAL);
  assign base_zero  = (out_tdata[39:20] == '0);
  assign idle_zero  = (out_tdata[19:0] == '0) && (out_tdata[72:40] == '0);
  assign beat       = {out_tuser, out_tdata};

  `DFBC_ASSERT_SAME(a_valid_only_run, out_tvalid && res_dvalid, is_run, "data_valid outside run")
  `DFBC_ASSERT_SAME(a_no_base_early, out_tvalid && is_early, base_zero, "baseline shown early")
  `DFBC_ASSERT_SAME(a_idle_zero, out_tvalid && !res_dvalid, idle_zero, "fields set while idle")
  `DFBC_ASSERT_SAME(a_sev_range, out_tvalid, res_sev <= SEV_SEVERE, "severity out of range")
  `DFBC_ASSERT_NEXT(a_stall_hold, stalled, out_tvalid && $stable(beat), "beat changed in stall")

endmodule

bind dual_flex_baseline_classifier dfbc_checker u_dfbc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
